/* hw/rtl/sfs_pkg.sv */
// Shared types and constants for the slot allocator with free stack.
package sfs_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = 6;
    localparam int HANDLE_W = 16;
    localparam int CNT_W    = 7;

    typedef enum logic
    {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_kind_t;

    typedef enum logic [1:0]
    {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2
    } status_t;

    typedef struct packed
    {
        logic                req_type;
        logic [HANDLE_W-1:0] handle_in;
        logic [SLOT_W-1:0]   slot_in;
    } req_t;

    typedef struct packed
    {
        logic [SLOT_W-1:0]   slot_out;
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          status;
        logic [CNT_W-1:0]    high_mark;
    } rsp_t;

endpackage

/* hw/rtl/sfs_ram.sv */
// Generic simple dual-port RAM with registered read.
module sfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/sfs_out_reg.sv */
// Response holding register between the allocator core and the response channel.
module sfs_out_reg
    import sfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    output logic can_load,
    input  rsp_t d,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign can_load = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

/* hw/rtl/slot_allocator_free_stack_unit.sv */
// Slot allocator top level: request control, occupancy bits, handle and stack RAMs.
// Flow: an accepted request is held in the request register while the RAMs read; its response and
// the table update are loaded when the response holding register can take them (it stalls on rsp_ready).
// A new request is taken only in the idle state, after the previous response has been loaded.
// Reset: occupancy bits, free count and high-water mark clear at once; RAMs are not cleared.
module slot_allocator_free_stack_unit
    import sfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [1:0]
    {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    fsm_t              state_reg;
    fsm_t              state_next;
    req_t              req_reg;
    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  used_next;
    logic [CNT_W-1:0]  fc_reg;
    logic [CNT_W-1:0]  fc_next;
    logic [CNT_W-1:0]  hw_reg;
    logic [CNT_W-1:0]  hw_next;
    logic [CNT_W-1:0]  fc_dec;
    logic [CNT_W-1:0]  hw_dec;
    logic              accept;
    logic              fire;
    logic              out_can_load;
    rsp_t              rsp_d;

    logic                h_we;
    logic [SLOT_W-1:0]   h_waddr;
    logic [HANDLE_W-1:0] h_rdata;
    logic                s_we;
    logic [SLOT_W-1:0]   s_rdata;
    logic [SLOT_W-1:0]   pos;
    logic                rel_ok;

    assign req_ready = (state_reg == FSM_IDLE);
    assign accept    = req_valid && req_ready;
    assign fire      = (state_reg == FSM_EXEC) && out_can_load;
    assign fc_dec    = fc_reg - 1'b1;
    assign hw_dec    = hw_reg - 1'b1;

    sfs_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SLOTS)
    ) u_handle_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (req_reg.handle_in),
        .re    (accept),
        .raddr (req.slot_in),
        .rdata (h_rdata)
    );

    sfs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (fc_reg[SLOT_W-1:0]),
        .wdata (req_reg.slot_in),
        .re    (accept),
        .raddr (fc_dec[SLOT_W-1:0]),
        .rdata (s_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        fc_next    = fc_reg;
        hw_next    = hw_reg;
        h_we       = 1'b0;
        h_waddr    = '0;
        s_we       = 1'b0;
        pos        = '0;
        rel_ok     = ({1'b0, req_reg.slot_in} < CNT_W'(SLOTS)) && used_reg[req_reg.slot_in];
        rsp_d      = '0;

        if (req_reg.req_type == REQ_ALLOC)
        begin
            rsp_d.status = STAT_OK;
            if (fc_reg != '0)
            begin
                pos     = s_rdata;
                fc_next = fc_dec;
            end
            else if (hw_reg < CNT_W'(SLOTS))
            begin
                pos     = hw_reg[SLOT_W-1:0];
                hw_next = hw_reg + 1'b1;
            end
            else
            begin
                rsp_d.status = STAT_FULL;
            end
            rsp_d.slot_out = pos;
            if (rsp_d.status == STAT_OK)
            begin
                h_we           = fire;
                h_waddr        = pos;
                used_next[pos] = 1'b1;
            end
        end
        else
        begin
            rsp_d.slot_out = req_reg.slot_in;
            if (!rel_ok)
            begin
                rsp_d.status = STAT_UNUSED;
            end
            else
            begin
                rsp_d.status     = STAT_OK;
                rsp_d.handle_out = h_rdata;
                used_next[req_reg.slot_in] = 1'b0;
                if ((hw_reg != '0) && ({1'b0, req_reg.slot_in} == hw_dec))
                begin
                    hw_next = hw_dec;
                end
                else
                begin
                    s_we    = fire;
                    fc_next = fc_reg + 1'b1;
                end
            end
        end
        rsp_d.high_mark = hw_next;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (fire)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            used_reg  <= '0;
            fc_reg    <= '0;
            hw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                used_reg <= used_next;
                fc_reg   <= fc_next;
                hw_reg   <= hw_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    sfs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .can_load  (out_can_load),
        .d         (rsp_d),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* tb/tb_slot_allocator_free_stack_unit.sv */
`timescale 1ns / 100ps
// Testbench for the slot allocator: queued request driver, response monitor, table predictor.
module tb_slot_allocator_free_stack_unit;
    import sfs_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 2000;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    slot_allocator_free_stack_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // predicted table state
    logic [HANDLE_W-1:0] slot_handle [SLOTS];
    bit                  slot_busy   [SLOTS];
    logic [SLOT_W-1:0]   freed_slots [SLOTS];
    int                  freed_depth = 0;
    int                  water       = 0;

    req_t req_backlog  [$];
    rsp_t rsp_expected [$];
    int   mismatches     = 0;
    bit   send_steady    = 1'b0;
    bit   recv_steady    = 1'b0;
    int   stall_requests = 0;
    int   stall_served   = 0;
    int   send_wait      = 0;
    int   recv_wait      = 0;
    int   hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (slot_busy[i])
        begin
            slot_busy[i] = 1'b0;
        end
    end

    function automatic rsp_t slot_table_step(req_t r);
        rsp_t o;
        int   pos;
        o = '0;
        if (r.req_type == REQ_ALLOC)
        begin
            if (freed_depth > 0)
            begin
                freed_depth--;
                pos = int'(freed_slots[freed_depth]);
            end
            else if (water < SLOTS)
            begin
                pos = water;
                water++;
            end
            else
            begin
                o.status    = STAT_FULL;
                o.high_mark = CNT_W'(water);
                return o;
            end
            slot_handle[pos] = r.handle_in;
            slot_busy[pos]   = 1'b1;
            o.slot_out       = SLOT_W'(pos);
            o.status         = STAT_OK;
        end
        else
        begin
            o.slot_out = r.slot_in;
            if (!slot_busy[r.slot_in])
            begin
                o.status = STAT_UNUSED;
            end
            else
            begin
                o.handle_out = slot_handle[r.slot_in];
                o.status     = STAT_OK;
                if (water > 0 && int'(r.slot_in) == water - 1)
                begin
                    water--;
                end
                else if (freed_depth < SLOTS)
                begin
                    freed_slots[freed_depth] = r.slot_in;
                    freed_depth++;
                end
                slot_busy[r.slot_in]   = 1'b0;
                slot_handle[r.slot_in] = '0;
            end
        end
        o.high_mark = CNT_W'(water);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        end
    endtask

    task automatic check_rsp(rsp_t got);
        rsp_t want;
        if (rsp_expected.size() == 0)
        begin
            report_mismatch("unexpected response", 32'(got), 32'd0);
            return;
        end
        want = rsp_expected.pop_front();
        if (got.slot_out !== want.slot_out)
            report_mismatch("slot_out", 32'(got.slot_out), 32'(want.slot_out));
        if (got.handle_out !== want.handle_out)
            report_mismatch("handle_out", 32'(got.handle_out), 32'(want.handle_out));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.high_mark !== want.high_mark)
            report_mismatch("high_mark", 32'(got.high_mark), 32'(want.high_mark));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_wait = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                rsp_expected.push_back(slot_table_step(req));
            end
            if (!req_valid || req_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    req       <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    send_wait = send_steady ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                check_rsp(rsp);
                recv_wait = recv_steady ? 0 : $urandom_range(0, 7);
            end
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    task automatic queue_request(req_kind_t kind, logic [HANDLE_W-1:0] h,
                                 logic [SLOT_W-1:0] s);
        req_t r;
        while (req_backlog.size() >= 2)
        begin
            @(posedge clk);
        end
        r.req_type  = kind;
        r.handle_in = h;
        r.slot_in   = s;
        req_backlog.push_back(r);
    endtask

    task automatic queue_random(int alloc_pct);
        int busy_list [$];
        logic [SLOT_W-1:0] s;
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            queue_request(REQ_ALLOC, HANDLE_W'($urandom()), SLOT_W'($urandom()));
        end
        else
        begin
            foreach (slot_busy[i])
            begin
                if (slot_busy[i])
                    busy_list.push_back(i);
            end
            if (busy_list.size() > 0 && $urandom_range(0, 99) < 85)
                s = SLOT_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            else
                s = SLOT_W'($urandom());
            queue_request(REQ_RELEASE, HANDLE_W'($urandom()), s);
        end
    endtask

    initial
    begin
        int alloc_mix [6];
        int drain;
        alloc_mix = '{80, 20, 95, 10, 60, 50};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, allocate at the extremes, top and non-top release, reuse
        queue_request(REQ_RELEASE, 16'hFFFF, 6'd0);
        queue_request(REQ_RELEASE, 16'h0000, 6'd63);
        queue_request(REQ_ALLOC,   16'h0000, 6'd63);
        queue_request(REQ_ALLOC,   16'hFFFF, 6'd0);
        queue_request(REQ_ALLOC,   16'h5A5A, 6'd21);
        queue_request(REQ_ALLOC,   16'hA5A5, 6'd42);
        queue_request(REQ_RELEASE, 16'h0000, 6'd3);
        queue_request(REQ_RELEASE, 16'hFFFF, 6'd1);
        queue_request(REQ_RELEASE, 16'h0000, 6'd0);
        queue_request(REQ_ALLOC,   16'h1234, 6'd0);
        queue_request(REQ_ALLOC,   16'h8001, 6'd0);
        queue_request(REQ_ALLOC,   16'h7FFE, 6'd0);
        queue_request(REQ_RELEASE, 16'h0000, 6'd1);
        queue_request(REQ_RELEASE, 16'h0000, 6'd1);
        queue_request(REQ_RELEASE, 16'h0000, 6'd2);
        queue_request(REQ_RELEASE, 16'h0000, 6'd3);
        queue_request(REQ_RELEASE, 16'h0000, 6'd2);

        for (int p = 0; p < 6; p++)
        begin
            send_steady = (p == 2);
            recv_steady = (p == 4);
            if (p == 2)
                stall_requests++;
            for (int n = 0; n < 80; n++)
            begin
                queue_random(alloc_mix[p]);
            end
        end

        // sample away from the driving edge so pending updates have settled
        do
        begin
            @(negedge clk);
        end
        while (req_backlog.size() > 0 || req_valid);
        drain = 0;
        while (rsp_expected.size() > 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (rsp_expected.size() > 0)
            report_mismatch("responses missing", 32'(rsp_expected.size()), 32'd0);

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_ram.sv
hw/rtl/sfs_out_reg.sv
hw/rtl/slot_allocator_free_stack_unit.sv
tb/tb_slot_allocator_free_stack_unit.sv
